[hdl/fsll_pkg.sv]
// fsll_pkg: shared types and constants of the four-sensor light log-likelihood block
// used by fsll_lane, fsll_merge and the top level four_sensor_light_log_likelihood
// no dependencies
package fsll_pkg;

    // number of sensors, one lane each
    localparam int NUM_LANES = 4;

    // fixed-point constants
    localparam logic [23:0] MU_MAX      = 24'hFFFFFF;
    localparam logic [23:0] UNIT_GAIN   = 24'h010000;
    localparam int          C_SQRT_Q16  = 1311;
    localparam int          C_LIN_Q16   = 3932;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam int          LOG_CONST   = 303185;
    localparam logic [25:0] Z_CLAMP     = 26'h2000000;

    // lane pipeline segments
    localparam int FRONT_STAGES = 4;
    localparam int MU_DIV_STEPS = 24;
    localparam int SQRT_STEPS   = 16;
    localparam int Z_DIV_STEPS  = 26;
    localparam int LOG_STEPS    = 16;
    localparam int LANE_DEPTH   = FRONT_STAGES + MU_DIV_STEPS + 1 + SQRT_STEPS + 1 + 1
                                + Z_DIV_STEPS + 2;
    // lane stages plus the merge stage
    localparam int PIPE_DEPTH   = LANE_DEPTH + 1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_GAIN_SECOND    = 3'd0,
        CFG_GAIN_THIRD     = 3'd1,
        CFG_GAIN_FOURTH    = 3'd2,
        CFG_PLANE_DISTANCE = 3'd3,
        CFG_SENSOR_XS      = 3'd4,
        CFG_SENSOR_YS      = 3'd5
    } cfg_index_t;

    // per-sensor result handed from a lane to the merge stage
    typedef struct packed {
        logic signed [35:0] term;
        logic               degen;
    } fsll_term_t;

endpackage

[hdl/four_sensor_light_log_likelihood.sv]
// Four-sensor light log-likelihood: takes one candidate item (amplitude, position and four
// observed sensor lights) per clock and returns its summed Gaussian log likelihood, at a sustained
// rate of one item per cycle unless halted. The per-sensor pipeline holds a 24-stage restoring
// divider for mu, a 16-stage square root and a 26-stage divider for z, one bit per stage, with the
// log2 squaring steps beside the latter. Four lanes, one per sensor, run in parallel and a merge
// stage adds and saturates their terms. The whole pipeline halts only while a result waits at the
// output and another is ready behind it. Configuration is written by the user through
// cfg_wen/cfg_index/cfg_wdata only while no item is in flight; the block does not enforce this.
// depends on fsll_pkg, fsll_lane, fsll_merge
module four_sensor_light_log_likelihood (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wen,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // observed_first, observed_second, observed_third, observed_fourth, amplitude,
    // pos_x, pos_y from the lowest bit up
    input  logic [151:0] s_tdata,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // log_likelihood
    output logic [31:0]  m_tdata,
    // degenerate
    output logic         m_tuser
);
    import fsll_pkg::*;

    // configuration registers
    logic [23:0] gain_second_reg, gain_third_reg, gain_fourth_reg;
    logic [15:0] plane_distance_reg;
    logic [63:0] sensor_xs_reg, sensor_ys_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_second_reg    <= UNIT_GAIN;
            gain_third_reg     <= UNIT_GAIN;
            gain_fourth_reg    <= UNIT_GAIN;
            plane_distance_reg <= '0;
            sensor_xs_reg      <= '0;
            sensor_ys_reg      <= '0;
        end else if (cfg_wen) begin
            case (cfg_index_t'(cfg_index))
                CFG_GAIN_SECOND:    gain_second_reg    <= cfg_wdata[23:0];
                CFG_GAIN_THIRD:     gain_third_reg     <= cfg_wdata[23:0];
                CFG_GAIN_FOURTH:    gain_fourth_reg    <= cfg_wdata[23:0];
                CFG_PLANE_DISTANCE: plane_distance_reg <= cfg_wdata[15:0];
                CFG_SENSOR_XS:      sensor_xs_reg      <= cfg_wdata;
                CFG_SENSOR_YS:      sensor_ys_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advance: stall only when a result waits and another is ready behind it
    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready || !vld_reg[PIPE_DEPTH-1];
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // per-sensor lanes
    logic [23:0]  gains [NUM_LANES];
    fsll_term_t   terms [NUM_LANES];

    assign gains[0] = UNIT_GAIN;
    assign gains[1] = gain_second_reg;
    assign gains[2] = gain_third_reg;
    assign gains[3] = gain_fourth_reg;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        fsll_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .obs    (s_tdata[24*l +: 24]),
            .amp    (s_tdata[119:96]),
            .gain   (gains[l]),
            .pos_x  (s_tdata[135:120]),
            .pos_y  (s_tdata[151:136]),
            .sens_x (sensor_xs_reg[16*l +: 16]),
            .sens_y (sensor_ys_reg[16*l +: 16]),
            .plane  (plane_distance_reg),
            .result (terms[l])
        );
    end

    // merge of lane terms
    logic signed [31:0] ll_sat;
    logic               degen_any;

    fsll_merge u_merge (
        .aclk           (aclk),
        .en             (en),
        .terms          (terms),
        .log_likelihood (ll_sat),
        .degenerate     (degen_any)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            m_tdata_reg <= ll_sat;
            m_tuser_reg <= degen_any;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[hdl/fsll_lane.sv]
// fsll_lane: one sensor's log-density term, fully pipelined, one item per cycle while en is high
// depends on fsll_pkg
module fsll_lane (
    input  logic               aclk,
    input  logic               en,
    input  logic [23:0]        obs,
    input  logic [23:0]        amp,
    input  logic [23:0]        gain,
    input  logic [15:0]        pos_x,
    input  logic [15:0]        pos_y,
    input  logic [15:0]        sens_x,
    input  logic [15:0]        sens_y,
    input  logic [15:0]        plane,
    output fsll_pkg::fsll_term_t result
);
    import fsll_pkg::*;

    // stage 1: coordinate differences and plane distance squared, amplitude times gain
    logic signed [16:0] dx, dy;
    logic signed [33:0] dx_sq, dy_sq;
    logic [32:0] dx2_reg, dy2_reg;
    logic [31:0] pd2_reg;
    logic [47:0] num_reg;
    logic [23:0] obs1_reg;

    assign dx = $signed({1'b0, pos_x}) - $signed({1'b0, sens_x});
    assign dy = $signed({1'b0, pos_y}) - $signed({1'b0, sens_y});
    assign dx_sq = 34'(dx) * 34'(dx);
    assign dy_sq = 34'(dy) * 34'(dy);

    always_ff @(posedge aclk) begin
        if (en) begin
            dx2_reg  <= dx_sq[32:0];
            dy2_reg  <= dy_sq[32:0];
            pd2_reg  <= 32'(plane) * 32'(plane);
            num_reg  <= 48'(amp) * 48'(gain);
            obs1_reg <= obs;
        end
    end

    // stage 2: squared distance, Q.10
    logic [33:0] r2;
    logic [23:0] r2q_reg;
    logic [47:0] num2_reg;
    logic [23:0] obs2_reg;

    assign r2 = {1'b0, dx2_reg} + {1'b0, dy2_reg} + {2'b0, pd2_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            r2q_reg  <= r2[33:10];
            num2_reg <= num_reg;
            obs2_reg <= obs1_reg;
        end
    end

    // stage 3: fourth power of distance
    logic [47:0] r4_reg;
    logic [51:0] num3_reg;
    logic [23:0] obs3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            r4_reg   <= 48'(r2q_reg) * 48'(r2q_reg);
            num3_reg <= {num2_reg, 4'b0};
            obs3_reg <= obs2_reg;
        end
    end

    // stage 4 and mu divider: saturation check, then one quotient bit per stage
    logic [47:0] md_rem_reg [0:MU_DIV_STEPS];
    logic [23:0] md_q_reg   [0:MU_DIV_STEPS];
    logic [23:0] md_low_reg [0:MU_DIV_STEPS];
    logic [47:0] md_r4_reg  [0:MU_DIV_STEPS];
    logic        md_sat_reg [0:MU_DIV_STEPS];
    logic [23:0] md_obs_reg [0:MU_DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            md_sat_reg[0] <= {20'b0, num3_reg[51:24]} >= r4_reg;
            md_rem_reg[0] <= {20'b0, num3_reg[51:24]};
            md_q_reg[0]   <= '0;
            md_low_reg[0] <= num3_reg[23:0];
            md_r4_reg[0]  <= r4_reg;
            md_obs_reg[0] <= obs3_reg;
        end
    end

    for (genvar j = 0; j < MU_DIV_STEPS; j++) begin : g_mu_div
        logic [48:0] trial;
        logic        take;
        assign trial = {md_rem_reg[j], md_low_reg[j][MU_DIV_STEPS-1-j]};
        assign take  = trial >= {1'b0, md_r4_reg[j]};
        always_ff @(posedge aclk) begin
            if (en) begin
                md_rem_reg[j+1] <= take ? 48'(trial - {1'b0, md_r4_reg[j]}) : trial[47:0];
                md_q_reg[j+1]   <= {md_q_reg[j][22:0], take};
                md_low_reg[j+1] <= md_low_reg[j];
                md_r4_reg[j+1]  <= md_r4_reg[j];
                md_sat_reg[j+1] <= md_sat_reg[j];
                md_obs_reg[j+1] <= md_obs_reg[j];
            end
        end
    end

    // mu select and square root of mu, one root bit per stage
    logic [23:0] mu_val;
    logic [31:0] sq_r_reg   [0:SQRT_STEPS];
    logic [15:0] sq_q_reg   [0:SQRT_STEPS];
    logic [23:0] sq_mu_reg  [0:SQRT_STEPS];
    logic [23:0] sq_obs_reg [0:SQRT_STEPS];

    assign mu_val = md_sat_reg[MU_DIV_STEPS] ? MU_MAX : md_q_reg[MU_DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_r_reg[0]   <= {mu_val, 8'b0};
            sq_q_reg[0]   <= '0;
            sq_mu_reg[0]  <= mu_val;
            sq_obs_reg[0] <= md_obs_reg[MU_DIV_STEPS];
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam int BIT = SQRT_STEPS - 1 - k;
        logic [33:0] tst;
        logic        take;
        assign tst  = ({18'b0, sq_q_reg[k]} << (BIT + 1)) + (34'd1 << (2 * BIT));
        assign take = {2'b0, sq_r_reg[k]} >= tst;
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_r_reg[k+1]   <= take ? 32'({2'b0, sq_r_reg[k]} - tst) : sq_r_reg[k];
                sq_q_reg[k+1]   <= take ? (sq_q_reg[k] | (16'd1 << BIT)) : sq_q_reg[k];
                sq_mu_reg[k+1]  <= sq_mu_reg[k];
                sq_obs_reg[k+1] <= sq_obs_reg[k];
            end
        end
    end

    // sigma and absolute deviation
    logic [23:0] mu_s, obs_s;
    logic [36:0] sig_full;
    logic [19:0] sigma_reg;
    logic [23:0] dev_reg;

    assign mu_s     = sq_mu_reg[SQRT_STEPS];
    assign obs_s    = sq_obs_reg[SQRT_STEPS];
    assign sig_full = 37'(sq_q_reg[SQRT_STEPS]) * 37'(C_SQRT_Q16)
                    + 37'(mu_s) * 37'(C_LIN_Q16) + 37'(32768);

    always_ff @(posedge aclk) begin
        if (en) begin
            sigma_reg <= sig_full[35:16];
            dev_reg   <= (obs_s >= mu_s) ? (obs_s - mu_s) : (mu_s - obs_s);
        end
    end

    // divider and log2 setup: overflow check of z, normalization of sigma
    logic [4:0]  lead;
    logic [30:0] norm;

    always_comb begin
        lead = '0;
        for (int b = 0; b < 20; b++) begin
            if (sigma_reg[b]) begin
                lead = 5'(b);
            end
        end
    end
    assign norm = {11'b0, sigma_reg} << (5'd30 - lead);

    logic [19:0] zd_rem_reg [0:Z_DIV_STEPS];
    logic [25:0] zd_q_reg   [0:Z_DIV_STEPS];
    logic [25:0] zd_low_reg [0:Z_DIV_STEPS];
    logic [19:0] zd_sig_reg [0:Z_DIV_STEPS];
    logic        zd_ovf_reg [0:Z_DIV_STEPS];
    logic [30:0] lg_m_reg   [0:Z_DIV_STEPS];
    logic [15:0] lg_f_reg   [0:Z_DIV_STEPS];
    logic [4:0]  lg_e_reg   [0:Z_DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            zd_ovf_reg[0] <= {6'b0, dev_reg[23:10]} >= sigma_reg;
            zd_rem_reg[0] <= {6'b0, dev_reg[23:10]};
            zd_q_reg[0]   <= '0;
            zd_low_reg[0] <= {dev_reg[9:0], 16'b0};
            zd_sig_reg[0] <= sigma_reg;
            lg_m_reg[0]   <= norm;
            lg_f_reg[0]   <= '0;
            lg_e_reg[0]   <= lead;
        end
    end

    // z divider with log2 squaring steps running alongside
    for (genvar j = 0; j < Z_DIV_STEPS; j++) begin : g_z_div
        logic [20:0] trial;
        logic        take;
        assign trial = {zd_rem_reg[j], zd_low_reg[j][Z_DIV_STEPS-1-j]};
        assign take  = trial >= {1'b0, zd_sig_reg[j]};
        always_ff @(posedge aclk) begin
            if (en) begin
                zd_rem_reg[j+1] <= take ? 20'(trial - {1'b0, zd_sig_reg[j]}) : trial[19:0];
                zd_q_reg[j+1]   <= {zd_q_reg[j][24:0], take};
                zd_low_reg[j+1] <= zd_low_reg[j];
                zd_sig_reg[j+1] <= zd_sig_reg[j];
                zd_ovf_reg[j+1] <= zd_ovf_reg[j];
                lg_e_reg[j+1]   <= lg_e_reg[j];
            end
        end

        if (j < LOG_STEPS) begin : g_log
            logic [61:0] msq;
            logic [31:0] mt;
            assign msq = 62'(lg_m_reg[j]) * 62'(lg_m_reg[j]);
            assign mt  = msq[61:30];
            always_ff @(posedge aclk) begin
                if (en) begin
                    lg_m_reg[j+1] <= mt[31] ? mt[31:1] : mt[30:0];
                    lg_f_reg[j+1] <= {lg_f_reg[j][14:0], mt[31]};
                end
            end
        end else begin : g_hold
            always_ff @(posedge aclk) begin
                if (en) begin
                    lg_m_reg[j+1] <= lg_m_reg[j];
                    lg_f_reg[j+1] <= lg_f_reg[j];
                end
            end
        end
    end

    // clamp and half square of z, natural log of sigma
    logic [25:0] z_raw, z_val;
    logic [51:0] z_sq;
    logic [52:0] ln_full;
    logic [33:0] half_reg;
    logic [20:0] ln_reg;
    logic        degen_reg;

    assign z_raw   = zd_q_reg[Z_DIV_STEPS];
    assign z_val   = (zd_ovf_reg[Z_DIV_STEPS] || z_raw > Z_CLAMP) ? Z_CLAMP : z_raw;
    assign z_sq    = 52'(z_val) * 52'(z_val);
    assign ln_full = 53'({lg_e_reg[Z_DIV_STEPS], lg_f_reg[Z_DIV_STEPS]}) * 53'(LN2_Q32)
                   + (53'd1 << 31);

    always_ff @(posedge aclk) begin
        if (en) begin
            half_reg  <= z_sq[50:17];
            ln_reg    <= ln_full[52:32];
            degen_reg <= (zd_sig_reg[Z_DIV_STEPS] == '0);
        end
    end

    // term of this sensor
    always_ff @(posedge aclk) begin
        if (en) begin
            result.term  <= 36'(LOG_CONST) - {15'b0, ln_reg} - {2'b0, half_reg};
            result.degen <= degen_reg;
        end
    end

endmodule

[hdl/fsll_merge.sv]
// fsll_merge: sums the four lane terms and saturates to Q16.16
// depends on fsll_pkg
module fsll_merge (
    input  logic                 aclk,
    input  logic                 en,
    input  fsll_pkg::fsll_term_t terms [fsll_pkg::NUM_LANES],
    output logic signed [31:0]   log_likelihood,
    output logic                 degenerate
);
    import fsll_pkg::*;

    logic signed [37:0] sum;
    logic               any_degen;
    logic signed [37:0] sum_reg;
    logic               degen_reg;

    // exact sum of the lane terms
    always_comb begin
        sum       = '0;
        any_degen = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            sum       = sum + 38'(terms[l].term);
            any_degen = any_degen | terms[l].degen;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= sum;
            degen_reg <= any_degen;
        end
    end

    // saturation, degenerate forces the minimum
    always_comb begin
        if (degen_reg || sum_reg < -38'sd2147483648) begin
            log_likelihood = 32'sh80000000;
        end else if (sum_reg > 38'sd2147483647) begin
            log_likelihood = 32'sh7FFFFFFF;
        end else begin
            log_likelihood = sum_reg[31:0];
        end
    end
    assign degenerate = degen_reg;

endmodule
